/* hw/rtl/vna_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vna_pkg;

  localparam int unsigned VNA_MAX_VERTICES = 64;

  localparam int unsigned CROSS_STEPS = 6;   // products of the cross product
  localparam int unsigned SQ_STEPS    = 3;   // squares summed into the squared length
  localparam int unsigned SQRT_STEPS  = 31;  // result bits of the square root
  localparam int unsigned DIV_STEPS   = 15;  // quotient bits per component

  typedef enum logic [1:0] {
    REQ_POS_WR = 2'd0,
    REQ_TRI    = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } vna_req_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DEC,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_EDG,
    ST_MUL,
    ST_RARD,
    ST_NLD,
    ST_SHF,
    ST_SQ,
    ST_SQI,
    ST_SQRT,
    ST_NCHK,
    ST_DLD,
    ST_DIT,
    ST_DST,
    ST_ARD,
    ST_AWR,
    ST_FIN
  } vna_state_e;

  typedef struct packed {
    logic       latch;
    logic       pos_wr;
    logic       pos_rd;
    logic       acc_clr;
    logic       acc_rd;
    logic       acc_wr;
    logic       cap_pa;
    logic       cap_e1;
    logic       cap_e2;
    logic       mul_en;
    logic       mul_sq;
    logic       mag_ld;
    logic       shift;
    logic       sqrt_init;
    logic       sqrt_en;
    logic       div_ld;
    logic       div_en;
    logic       div_st;
    logic       zero_nrm;
    logic       out_ld;
    logic [1:0] comp;
    logic [4:0] cnt;
  } vna_cmd_t;

  typedef struct packed {
    vna_req_e req;
    logic     rng_v;
    logic     rng_tri;
    logic     mag_big;
    logic     len_zero;
    logic     out_free;
  } vna_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/vertex_normal_accumulate.sv */
// Time from accept to result in the output register is set by the 31-step square root,
// any magnitude reduction shifts and the three divides, plus any wait for the output
// register to free up; position writes and clears go straight to the output register,
// and a zero sum or a zero-area face skips the divides.
// One item at a time: the next item is taken the cycle after the result is registered.
// Reset (async, active low) clears controller, output valid and accumulator valid bits.
`timescale 1ns / 1ps
`default_nettype none

module vertex_normal_accumulate import vna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = VNA_MAX_VERTICES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [1:0]  req_type_i,
  input  wire logic        [5:0]  vertex_index_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [23:0] pos_z_i,
  input  wire logic        [5:0]  corner_a_i,
  input  wire logic        [5:0]  corner_b_i,
  input  wire logic        [5:0]  corner_c_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      normal_x_o,
  output logic signed [15:0]      normal_y_o,
  output logic signed [15:0]      normal_z_o,
  output logic                    zero_length_o
);

  // Controller sequences each item through the datapath:
  //   triangle: three position reads, edges, six-product cross product on one
  //   shared multiplier, magnitude reduction, three squares, square root, three
  //   divides, then a read-modify-write of each corner accumulator.
  //   read: one accumulator read, then the same normalize steps.
  vna_cmd_t cmd;
  vna_sts_t sts;

  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vna_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .vertex_index_i (vertex_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .corner_a_i     (corner_a_i),
    .corner_b_i     (corner_b_i),
    .corner_c_i     (corner_c_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .zero_length_o  (zero_length_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/vna_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module vna_ctrl import vna_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire vna_sts_t sts_i,
  output vna_cmd_t      cmd_o
);

  vna_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = '0;
    comp_d     = comp_q;
    cmd_o      = '0;
    cmd_o.cnt  = cnt_q;
    cmd_o.comp = comp_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DEC;
        end
      end
      ST_DEC: begin
        comp_d = '0;
        unique case (sts_i.req)
          REQ_POS_WR: begin
            cmd_o.pos_wr = sts_i.rng_v;
            state_d      = ST_FIN;
          end
          REQ_CLEAR: begin
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_FIN;
          end
          REQ_TRI:  state_d = sts_i.rng_tri ? ST_RDA : ST_FIN;
          REQ_READ: state_d = sts_i.rng_v ? ST_RARD : ST_FIN;
          default:  state_d = ST_FIN;
        endcase
      end
      ST_RDA: begin
        cmd_o.pos_rd = 1'b1;
        cmd_o.comp   = 2'd0;
        state_d      = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.pos_rd = 1'b1;
        cmd_o.comp   = 2'd1;
        cmd_o.cap_pa = 1'b1;
        state_d      = ST_RDC;
      end
      ST_RDC: begin
        cmd_o.pos_rd = 1'b1;
        cmd_o.comp   = 2'd2;
        cmd_o.cap_e1 = 1'b1;
        state_d      = ST_EDG;
      end
      ST_EDG: begin
        cmd_o.cap_e2 = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (cnt_q == 5'(CROSS_STEPS)) state_d = ST_NLD;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_RARD: begin
        cmd_o.acc_rd = 1'b1;
        state_d      = ST_NLD;
      end
      ST_NLD: begin
        cmd_o.mag_ld = 1'b1;
        state_d      = ST_SHF;
      end
      ST_SHF: begin
        if (sts_i.mag_big) cmd_o.shift = 1'b1;
        else state_d = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sq = 1'b1;
        if (cnt_q == 5'(SQ_STEPS)) state_d = ST_SQI;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        state_d         = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_en = 1'b1;
        if (cnt_q == 5'(SQRT_STEPS - 1)) state_d = ST_NCHK;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_NCHK: begin
        comp_d = '0;
        if (sts_i.len_zero) begin
          cmd_o.zero_nrm = 1'b1;
          state_d        = (sts_i.req == REQ_TRI) ? ST_ARD : ST_FIN;
        end else begin
          state_d = ST_DLD;
        end
      end
      ST_DLD: begin
        cmd_o.div_ld = 1'b1;
        state_d      = ST_DIT;
      end
      ST_DIT: begin
        cmd_o.div_en = 1'b1;
        if (cnt_q == 5'(DIV_STEPS - 1)) state_d = ST_DST;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_DST: begin
        cmd_o.div_st = 1'b1;
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          state_d = (sts_i.req == REQ_TRI) ? ST_ARD : ST_FIN;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_DLD;
        end
      end
      ST_ARD: begin
        cmd_o.acc_rd = 1'b1;
        state_d      = ST_AWR;
      end
      ST_AWR: begin
        cmd_o.acc_wr = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = ST_FIN;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_ARD;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/vna_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module vna_datapath import vna_pkg::*; #(
  parameter int unsigned MAX_VERTICES = VNA_MAX_VERTICES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic        [1:0]  req_type_i,
  input  wire logic        [5:0]  vertex_index_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [23:0] pos_z_i,
  input  wire logic        [5:0]  corner_a_i,
  input  wire logic        [5:0]  corner_b_i,
  input  wire logic        [5:0]  corner_c_i,
  input  wire vna_cmd_t           cmd_i,
  output vna_sts_t                sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      normal_x_o,
  output logic signed [15:0]      normal_y_o,
  output logic signed [15:0]      normal_z_o,
  output logic                    zero_length_o
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  function automatic logic [AW-1:0] to_addr(input logic [5:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[AW-1:0];
  endfunction

  function automatic logic in_rng(input logic [5:0] idx);
    return 32'(idx) < MAX_VERTICES;
  endfunction

  function automatic logic signed [23:0] word_comp(input logic [71:0] w,
                                                   input int k);
    return $signed(w[71-24*k -: 24]);
  endfunction

  // latched item
  vna_req_e          req_q;
  logic [5:0]        vi_q, ca_q, cb_q, cc_q;
  logic [71:0]       pos_in_q;

  logic [5:0]        sel_idx;
  logic [AW-1:0]     pos_addr, acc_addr;

  logic [71:0]       pos_mem [MAX_VERTICES];
  logic [71:0]       pos_rd_q, pa_q;
  logic [71:0]       acc_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] acc_vld_q;
  logic [71:0]       acc_rd_q;
  logic              acc_rd_vld_q;
  logic signed [23:0] acc_eff [3];
  logic [71:0]       acc_sum;

  logic signed [24:0] e1_q [3];
  logic signed [24:0] e2_q [3];
  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] prod_q;
  logic signed [50:0] cr_q [3];
  logic [2:0]         mj;

  logic [50:0]        mag_q [3];
  logic [2:0]         neg_q;
  logic [61:0]        len2_q;

  logic [61:0]        rem_q, sres_q, bit_q, sq_sum;
  logic [30:0]        len;

  logic [44:0]        dnum_q, dvs_q;
  logic [14:0]        quo_q, quo_c;

  logic signed [15:0] n_q [3];
  logic               flag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= vna_req_e'(req_type_i);
      vi_q     <= vertex_index_i;
      ca_q     <= corner_a_i;
      cb_q     <= corner_b_i;
      cc_q     <= corner_c_i;
      pos_in_q <= {pos_x_i, pos_y_i, pos_z_i};
    end
  end

  always_comb begin
    case (cmd_i.comp)
      2'd0:    sel_idx = ca_q;
      2'd1:    sel_idx = cb_q;
      default: sel_idx = cc_q;
    endcase
  end

  assign pos_addr = cmd_i.pos_wr ? to_addr(vi_q) : to_addr(sel_idx);
  assign acc_addr = (req_q == REQ_READ) ? to_addr(vi_q) : to_addr(sel_idx);

  // position store
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_wr) pos_mem[pos_addr] <= pos_in_q;
    if (cmd_i.pos_rd) pos_rd_q <= pos_mem[pos_addr];
  end

  // accumulator store; an entry without its valid bit reads as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_wr) acc_mem[acc_addr] <= acc_sum;
    if (cmd_i.acc_rd) begin
      acc_rd_q     <= acc_mem[acc_addr];
      acc_rd_vld_q <= acc_vld_q[acc_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (cmd_i.acc_clr) begin
      acc_vld_q <= '0;
    end else if (cmd_i.acc_wr) begin
      acc_vld_q[acc_addr] <= 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [24:0] t;
      acc_eff[k] = acc_rd_vld_q ? word_comp(acc_rd_q, k) : 24'sd0;
      t = 25'(acc_eff[k]) + 25'(n_q[k]);
      if (t > 25'sd8388607)       acc_sum[71-24*k -: 24] = 24'h7FFFFF;
      else if (t < -25'sd8388608) acc_sum[71-24*k -: 24] = 24'h800000;
      else                        acc_sum[71-24*k -: 24] = t[23:0];
    end
  end

  // edges
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_pa) pa_q <= pos_rd_q;
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.cap_e1) e1_q[k] <= 25'(word_comp(pos_rd_q, k)) - 25'(word_comp(pa_q, k));
      if (cmd_i.cap_e2) e2_q[k] <= 25'(word_comp(pos_rd_q, k)) - 25'(word_comp(pa_q, k));
    end
  end

  // shared multiplier: cross product terms, then squares of the reduced magnitudes
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul_sq) begin
      case (cmd_i.cnt)
        5'd0: begin
          mul_a = $signed({1'b0, mag_q[0][29:0]});
          mul_b = $signed({1'b0, mag_q[0][29:0]});
        end
        5'd1: begin
          mul_a = $signed({1'b0, mag_q[1][29:0]});
          mul_b = $signed({1'b0, mag_q[1][29:0]});
        end
        5'd2: begin
          mul_a = $signed({1'b0, mag_q[2][29:0]});
          mul_b = $signed({1'b0, mag_q[2][29:0]});
        end
        default: ;
      endcase
    end else begin
      case (cmd_i.cnt)
        5'd0: begin mul_a = 31'(e1_q[1]); mul_b = 31'(e2_q[2]); end
        5'd1: begin mul_a = 31'(e1_q[2]); mul_b = 31'(e2_q[1]); end
        5'd2: begin mul_a = 31'(e1_q[2]); mul_b = 31'(e2_q[0]); end
        5'd3: begin mul_a = 31'(e1_q[0]); mul_b = 31'(e2_q[2]); end
        5'd4: begin mul_a = 31'(e1_q[0]); mul_b = 31'(e2_q[1]); end
        5'd5: begin mul_a = 31'(e1_q[1]); mul_b = 31'(e2_q[0]); end
        default: ;
      endcase
    end
  end

  assign mj = cmd_i.cnt[2:0] - 3'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
      if (cmd_i.mul_sq) begin
        if (cmd_i.cnt == 5'd0) len2_q <= '0;
        else len2_q <= len2_q + 62'(prod_q);
      end else if (cmd_i.cnt != 5'd0) begin
        if (!mj[0]) cr_q[mj[2:1]] <= 51'(prod_q);
        else        cr_q[mj[2:1]] <= cr_q[mj[2:1]] - 51'(prod_q);
      end
    end
  end

  // magnitudes, reduced one bit a cycle until all fit in 30 bits
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [50:0] src;
      src = (req_q == REQ_TRI) ? cr_q[k] : 51'(acc_eff[k]);
      if (cmd_i.mag_ld) begin
        neg_q[k] <= src[50];
        mag_q[k] <= src[50] ? 51'(-src) : 51'(src);
      end else if (cmd_i.shift) begin
        mag_q[k] <= mag_q[k] >> 1;
      end
    end
  end

  // bitwise integer square root
  assign sq_sum = sres_q + bit_q;
  assign len    = sres_q[30:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rem_q  <= len2_q;
      sres_q <= '0;
      bit_q  <= 62'(1) << 60;
    end else if (cmd_i.sqrt_en) begin
      if (rem_q >= sq_sum) begin
        rem_q  <= rem_q - sq_sum;
        sres_q <= (sres_q >> 1) + bit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // restoring divide, one quotient bit a cycle
  assign quo_c = (quo_q > 15'd16384) ? 15'd16384 : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld) begin
      dnum_q <= 45'({mag_q[cmd_i.comp][29:0], 14'b0}) + 45'(len >> 1);
      dvs_q  <= {len, 14'b0};
      quo_q  <= '0;
    end else if (cmd_i.div_en) begin
      if (dnum_q >= dvs_q) dnum_q <= dnum_q - dvs_q;
      quo_q <= {quo_q[13:0], dnum_q >= dvs_q};
      dvs_q <= dvs_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch || cmd_i.zero_nrm) begin
      for (int k = 0; k < 3; k++) n_q[k] <= '0;
      flag_q <= cmd_i.zero_nrm;
    end else if (cmd_i.div_st) begin
      n_q[cmd_i.comp] <= neg_q[cmd_i.comp] ? -$signed(16'(quo_c)) : $signed(16'(quo_c));
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      normal_x_o    <= (req_q == REQ_READ) ? n_q[0] : 16'sd0;
      normal_y_o    <= (req_q == REQ_READ) ? n_q[1] : 16'sd0;
      normal_z_o    <= (req_q == REQ_READ) ? n_q[2] : 16'sd0;
      zero_length_o <= flag_q;
    end
  end

  assign sts_o.req      = req_q;
  assign sts_o.rng_v    = in_rng(vi_q);
  assign sts_o.rng_tri  = in_rng(ca_q) && in_rng(cb_q) && in_rng(cc_q);
  assign sts_o.mag_big  = (|mag_q[0][50:30]) || (|mag_q[1][50:30]) || (|mag_q[2][50:30]);
  assign sts_o.len_zero = (sres_q == '0);
  assign sts_o.out_free = !out_valid_o || !out_stall_i;

endmodule

`default_nettype wire

/* hw/rtl/vna_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module vna_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [15:0] normal_x_o,
  input wire logic signed [15:0] normal_y_o,
  input wire logic signed [15:0] normal_z_o,
  input wire logic               zero_length_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item in flight: busy right after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // zero-length flag comes with a zero vector
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |->
      normal_x_o == 16'sd0 && normal_y_o == 16'sd0 && normal_z_o == 16'sd0)
    else $error("zero length with nonzero normal");

  // unit components stay within one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      normal_x_o <= 16'sd16384 && normal_x_o >= -16'sd16384 &&
      normal_y_o <= 16'sd16384 && normal_y_o >= -16'sd16384 &&
      normal_z_o <= 16'sd16384 && normal_z_o >= -16'sd16384)
    else $error("normal component out of range");

endmodule

bind vertex_normal_accumulate vna_checker u_vna_checker (.*);

`default_nettype wire
